// ===== rtl/mlk_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package mlk_pkg;

	localparam int unsigned CharW    = 8;
	localparam int unsigned TimeW    = 16;
	localparam int unsigned CfgIdxW  = 8;
	localparam int unsigned OutDataW = 24;

	localparam logic [CfgIdxW-1:0] REG_DOT        = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_DASH       = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_SYMBOL_GAP = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_LETTER_GAP = 8'd3;

	localparam logic [TimeW-1:0] DOT_RESET        = 16'd500;
	localparam logic [TimeW-1:0] DASH_RESET       = 16'd1000;
	localparam logic [TimeW-1:0] SYMBOL_GAP_RESET = 16'd500;
	localparam logic [TimeW-1:0] LETTER_GAP_RESET = 16'd1000;

	localparam logic [CharW-1:0] CHAR_UPPER_A = 8'h41;
	localparam logic [CharW-1:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [CharW-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CharW-1:0] CHAR_LOWER_Z = 8'h7A;

	// symbol count 1..4, pattern first symbol in highest used bit, 1 = dash
	typedef struct packed {
		logic [2:0] count;
		logic [3:0] bits;
	} code_t;

	typedef struct packed {
		logic [TimeW-1:0] dot;
		logic [TimeW-1:0] dash;
		logic [TimeW-1:0] symbol_gap;
		logic [TimeW-1:0] letter_gap;
	} timing_t;

	function automatic code_t letter_code(input logic [4:0] idx);
		code_t c;
		case (idx)
			5'd0:  c = '{3'd2, 4'h1}; // A
			5'd1:  c = '{3'd4, 4'h8}; // B
			5'd2:  c = '{3'd4, 4'hA}; // C
			5'd3:  c = '{3'd3, 4'h4}; // D
			5'd4:  c = '{3'd1, 4'h0}; // E
			5'd5:  c = '{3'd4, 4'h2}; // F
			5'd6:  c = '{3'd3, 4'h6}; // G
			5'd7:  c = '{3'd4, 4'h0}; // H
			5'd8:  c = '{3'd2, 4'h0}; // I
			5'd9:  c = '{3'd4, 4'h7}; // J
			5'd10: c = '{3'd3, 4'h5}; // K
			5'd11: c = '{3'd4, 4'h4}; // L
			5'd12: c = '{3'd2, 4'h3}; // M
			5'd13: c = '{3'd2, 4'h2}; // N
			5'd14: c = '{3'd3, 4'h7}; // O
			5'd15: c = '{3'd4, 4'h6}; // P
			5'd16: c = '{3'd4, 4'hD}; // Q
			5'd17: c = '{3'd3, 4'h2}; // R
			5'd18: c = '{3'd3, 4'h0}; // S
			5'd19: c = '{3'd1, 4'h1}; // T
			5'd20: c = '{3'd3, 4'h1}; // U
			5'd21: c = '{3'd4, 4'h1}; // V
			5'd22: c = '{3'd3, 4'h3}; // W
			5'd23: c = '{3'd4, 4'h9}; // X
			5'd24: c = '{3'd4, 4'hB}; // Y
			5'd25: c = '{3'd4, 4'hC}; // Z
			default: c = '{3'd1, 4'h0};
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/morse_letter_keyer_top.sv =====
// Morse letter keyer: one ASCII character in, its Morse pattern out as LED segments.
// Input stream s_*: one beat per character (tdata = char_code). A-Z and a-z encode,
// any other code is taken and dropped without output.
// Output stream m_*: one beat per segment, tdata[0] = led_on, tdata[16:1] =
// duration_ms, tlast marks the closing letter gap. A letter of n symbols yields
// 2n beats: mark, symbol gap, ..., mark, letter gap.
// Config channel cfg_*: cfg_index 0..3 selects dot, dash, symbol gap, letter gap
// time (ms); other indexes are ignored. Write only while the block is idle.
// Path: a character beat is written into the queue, popped by the idle sequencer, and
// its first segment then registered. The back-end sequencer emits one segment per cycle
// while the output slot is free, and passes through its idle state to load the next letter.
// A 2-entry queue between classifier and sequencer keeps s_tready high while a
// letter is being sent; s_tready drops only when the queue is full.
// When m_tready is low the output register holds its beat and the sequencer waits.
// Reset: queue empty, no output pending, timings 500/1000/500/1000 ms.
`timescale 1ns / 1ps
`default_nettype none
module morse_letter_keyer_top (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	input  wire logic [mlk_pkg::CharW-1:0]    s_tdata,     // char_code
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	output logic [mlk_pkg::OutDataW-1:0]      m_tdata,     // led_on, duration_ms, zero pad
	output logic                              m_tlast,     // last_segment
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [mlk_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [mlk_pkg::TimeW-1:0]    cfg_data
);

	mlk_pkg::timing_t timing_q;
	mlk_pkg::code_t   push_code;
	mlk_pkg::code_t   head;
	logic             push;
	logic             pop;
	logic             q_empty;
	logic             q_full;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.dot        <= mlk_pkg::DOT_RESET;
			timing_q.dash       <= mlk_pkg::DASH_RESET;
			timing_q.symbol_gap <= mlk_pkg::SYMBOL_GAP_RESET;
			timing_q.letter_gap <= mlk_pkg::LETTER_GAP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				mlk_pkg::REG_DOT:        timing_q.dot        <= cfg_data;
				mlk_pkg::REG_DASH:       timing_q.dash       <= cfg_data;
				mlk_pkg::REG_SYMBOL_GAP: timing_q.symbol_gap <= cfg_data;
				mlk_pkg::REG_LETTER_GAP: timing_q.letter_gap <= cfg_data;
				default: ;
			endcase
		end
	end

	mlk_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (push),
		.q_code   (push_code)
	);

	mlk_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_code (push_code),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty),
		.full      (q_full)
	);

	mlk_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.timing   (timing_q),
		.head     (head),
		.empty    (q_empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== rtl/mlk_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlk_front (
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [mlk_pkg::CharW-1:0] s_tdata,   // char_code
	input  wire logic                     q_full,
	output logic                          q_push,
	output mlk_pkg::code_t                q_code
);

	logic                      is_upper;
	logic                      is_lower;
	logic [mlk_pkg::CharW-1:0] offs;

	always_comb begin
		is_upper = s_tdata inside {[mlk_pkg::CHAR_UPPER_A : mlk_pkg::CHAR_UPPER_Z]};
		is_lower = s_tdata inside {[mlk_pkg::CHAR_LOWER_A : mlk_pkg::CHAR_LOWER_Z]};
		offs     = is_upper ? (s_tdata - mlk_pkg::CHAR_UPPER_A)
		                    : (s_tdata - mlk_pkg::CHAR_LOWER_A);
	end

	// non-letters are taken and dropped
	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full && (is_upper || is_lower);
	assign q_code   = mlk_pkg::letter_code(offs[4:0]);

endmodule
`default_nettype wire

// ===== rtl/mlk_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlk_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mlk_pkg::code_t push_code,
	input  wire logic           pop,
	output mlk_pkg::code_t      head,
	output logic                empty,
	output logic                full
);

	mlk_pkg::code_t mem_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;

	assign empty = (cnt_q == 2'd0);
	assign full  = (cnt_q == 2'd2);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		empty |-> !pop) else $error("queue pop while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/mlk_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module mlk_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mlk_pkg::timing_t timing,
	input  wire mlk_pkg::code_t  head,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [mlk_pkg::OutDataW-1:0] m_tdata,   // led_on, duration_ms, zero pad
	output logic                 m_tlast           // last_segment
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MARK = 4'b0010,
		S_GAP  = 4'b0100,
		S_END  = 4'b1000
	} state_t;

	state_t                     state_q;
	mlk_pkg::code_t             code_q;
	logic [2:0]                 left_q;     // symbols not yet sent
	logic                       out_valid_q;
	logic                       out_led_q;
	logic [mlk_pkg::TimeW-1:0]  out_dur_q;
	logic                       out_last_q;
	logic                       slot_free;
	logic                       seg_emit;
	logic [1:0]                 bit_idx;
	logic                       is_dash;

	assign slot_free = !out_valid_q || m_tready;
	assign seg_emit  = slot_free &&
		(state_q == S_MARK || state_q == S_GAP || state_q == S_END);
	assign bit_idx   = left_q[1:0] - 2'd1;
	assign is_dash   = code_q.bits[bit_idx];
	assign pop       = (state_q == S_IDLE) && !empty;

	always_ff @(posedge clk) begin
		if (pop) begin
			code_q <= head;
		end
		if (slot_free) begin
			case (state_q)
				S_MARK: begin
					out_led_q  <= 1'b1;
					out_dur_q  <= is_dash ? timing.dash : timing.dot;
					out_last_q <= 1'b0;
				end
				S_GAP: begin
					out_led_q  <= 1'b0;
					out_dur_q  <= timing.symbol_gap;
					out_last_q <= 1'b0;
				end
				default: begin
					out_led_q  <= 1'b0;
					out_dur_q  <= timing.letter_gap;
					out_last_q <= 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			left_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (seg_emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						left_q  <= head.count;
						state_q <= S_MARK;
					end
				end
				S_MARK: begin
					if (slot_free) begin
						state_q <= (left_q == 3'd1) ? S_END : S_GAP;
					end
				end
				S_GAP: begin
					if (slot_free) begin
						left_q  <= left_q - 3'd1;
						state_q <= S_MARK;
					end
				end
				S_END: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mlk_pkg::OutDataW - mlk_pkg::TimeW - 1){1'b0}}, out_dur_q, out_led_q};
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	a_last_is_off: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> !out_led_q) else $error("closing segment with LED on");
	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END && slot_free) |=> (state_q == S_IDLE && m_tvalid && m_tlast))
		else $error("letter gap not emitted at end of letter");
	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK || state_q == S_GAP) |-> (left_q != 3'd0 && left_q <= 3'd4))
		else $error("symbol counter out of range");
`endif

endmodule
`default_nettype wire

// ===== verif/morse_letter_keyer_top_test.sv =====
`timescale 1ns / 1ps
module morse_letter_keyer_top_test;

	localparam int unsigned HOLD_CYCLES    = 300;
	localparam int unsigned STALL_LIMIT    = 4000;
	localparam int unsigned DRAIN_CYCLES   = 12;
	localparam int unsigned N_PHASES       = 6;
	localparam int unsigned RAND_PER_PHASE = 66;
	localparam int unsigned DIR_N          = 24;

	typedef logic [mlk_pkg::CharW-1:0]   char_t;
	typedef logic [mlk_pkg::TimeW-1:0]   ms_t;
	typedef logic [mlk_pkg::CfgIdxW-1:0] cfg_idx_t;

	typedef struct packed {
		logic led;
		ms_t  ms;
		logic last;
	} seg_t;

	typedef struct packed {
		char_t      code;
		logic       typed;
		logic [1:0] n_segs;
		seg_t       s0;
		seg_t       s1;
	} dir_row_t;

	localparam seg_t NO_SEG = '0;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	char_t                        s_tdata;   // char_code
	logic                         m_tvalid;
	logic                         m_tready;
	logic [mlk_pkg::OutDataW-1:0] m_tdata;   // led_on, duration_ms, zero pad
	logic                         m_tlast;   // last_segment
	logic                         cfg_valid;
	logic                         cfg_ready;
	cfg_idx_t                     cfg_index;
	ms_t                          cfg_data;

	morse_letter_keyer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// dots and dashes per letter, first symbol sent first
	string morse_pat [0:25] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--.."
	};

	// timings as the block should hold them
	ms_t dot_ms;
	ms_t dash_ms;
	ms_t sgap_ms;
	ms_t lgap_ms;

	seg_t        pending_segs[$];
	int unsigned err_cnt;
	int unsigned seg_cnt;
	int unsigned stall_cycles;
	bit          no_idle;
	bit          hold_req;

	// typed rows use the timings after reset
	dir_row_t dir_tab [0:DIR_N-1] = '{
		'{8'h45, 1'b1, 2'd2, '{1'b1, 16'd500, 1'b0},  '{1'b0, 16'd1000, 1'b1}}, // E
		'{8'h54, 1'b1, 2'd2, '{1'b1, 16'd1000, 1'b0}, '{1'b0, 16'd1000, 1'b1}}, // T
		'{8'h65, 1'b1, 2'd2, '{1'b1, 16'd500, 1'b0},  '{1'b0, 16'd1000, 1'b1}}, // e
		'{8'h74, 1'b1, 2'd2, '{1'b1, 16'd1000, 1'b0}, '{1'b0, 16'd1000, 1'b1}}, // t
		'{8'h00, 1'b1, 2'd0, NO_SEG, NO_SEG},
		'{8'hFF, 1'b1, 2'd0, NO_SEG, NO_SEG},
		'{8'h40, 1'b1, 2'd0, NO_SEG, NO_SEG}, // just below A
		'{8'h5B, 1'b1, 2'd0, NO_SEG, NO_SEG}, // just above Z
		'{8'h60, 1'b1, 2'd0, NO_SEG, NO_SEG}, // just below a
		'{8'h7B, 1'b1, 2'd0, NO_SEG, NO_SEG}, // just above z
		'{8'h80, 1'b1, 2'd0, NO_SEG, NO_SEG},
		'{8'h7F, 1'b1, 2'd0, NO_SEG, NO_SEG},
		'{8'h41, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h5A, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h61, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h7A, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h43, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h46, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h51, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h59, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h48, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h4F, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h6A, 1'b0, 2'd0, NO_SEG, NO_SEG},
		'{8'h30, 1'b1, 2'd0, NO_SEG, NO_SEG}
	};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// segments a character should produce under the current timings
	function automatic void queue_segments(input char_t code);
		string pat;
		int    idx;
		int    i;
		if (code >= mlk_pkg::CHAR_UPPER_A && code <= mlk_pkg::CHAR_UPPER_Z) begin
			idx = int'(code - mlk_pkg::CHAR_UPPER_A);
		end else if (code >= mlk_pkg::CHAR_LOWER_A && code <= mlk_pkg::CHAR_LOWER_Z) begin
			idx = int'(code - mlk_pkg::CHAR_LOWER_A);
		end else begin
			return;
		end
		pat = morse_pat[idx];
		for (i = 0; i < pat.len(); i++) begin
			pending_segs.push_back(seg_t'{1'b1, (pat[i] == "-") ? dash_ms : dot_ms, 1'b0});
			if (i + 1 < pat.len())
				pending_segs.push_back(seg_t'{1'b0, sgap_ms, 1'b0});
		end
		pending_segs.push_back(seg_t'{1'b0, lgap_ms, 1'b1});
	endfunction

	// called at a rising edge; returns at the edge where the character beat is taken
	task automatic send_char(input char_t code);
		while (!no_idle && $urandom_range(99) < 22) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= code;
		@(negedge clk);
		while (!s_tready)
			@(negedge clk);
		@(posedge clk);
	endtask

	// cfg_valid is left high; the caller lowers it after the last write
	task automatic cfg_write(input cfg_idx_t idx, input ms_t val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready)
			@(negedge clk);
		@(posedge clk);
		case (idx)
			mlk_pkg::REG_DOT:        dot_ms  = val;
			mlk_pkg::REG_DASH:       dash_ms = val;
			mlk_pkg::REG_SYMBOL_GAP: sgap_ms = val;
			mlk_pkg::REG_LETTER_GAP: lgap_ms = val;
			default: ;
		endcase
	endtask

	task automatic program_timing(input ms_t dot, input ms_t dash,
			input ms_t sgap, input ms_t lgap,
			input cfg_idx_t stray_idx);
		cfg_write(stray_idx, ms_t'($urandom));
		cfg_write(mlk_pkg::REG_LETTER_GAP, lgap);
		cfg_write(mlk_pkg::REG_DOT, dot);
		cfg_write(mlk_pkg::REG_SYMBOL_GAP, sgap);
		cfg_write(mlk_pkg::REG_DASH, dash);
		cfg_valid <= 1'b0;
	endtask

	// a dropped character may still be in flight when the queue runs empty
	task automatic wait_drained;
		while (pending_segs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic char_t rand_char;
		char_t base;
		if ($urandom_range(99) < 20)
			return char_t'($urandom_range(255));
		base = $urandom_range(1) ? mlk_pkg::CHAR_LOWER_A : mlk_pkg::CHAR_UPPER_A;
		return base + char_t'($urandom_range(25));
	endfunction

	// receiver: random stalls, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= no_idle || ($urandom_range(99) >= 22);
		end
	end

	// outputs are stable at the falling edge, so a beat seen here is taken at the next rise
	always @(negedge clk) begin
		seg_t got;
		seg_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{m_tdata[0], m_tdata[mlk_pkg::TimeW:1], m_tlast};
			if (pending_segs.size() == 0) begin
				$display("%0t: unexpected segment led=%0b ms=%0d last=%0b",
					$time, got.led, got.ms, got.last);
				err_cnt++;
			end else begin
				want = pending_segs.pop_front();
				if (got.led !== want.led || got.ms !== want.ms || got.last !== want.last) begin
					$display("%0t: segment %0d expected led=%0b ms=%0d last=%0b, actual led=%0b ms=%0d last=%0b",
						$time, seg_cnt, want.led, want.ms, want.last,
						got.led, got.ms, got.last);
					err_cnt++;
				end
			end
			seg_cnt++;
		end
	end

	always @(negedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
			$display("[morse_letter_keyer_top] ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned ph;
		int unsigned k;
		char_t c;
		err_cnt      = 0;
		seg_cnt      = 0;
		stall_cycles = 0;
		no_idle      = 1'b0;
		hold_req     = 1'b0;
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		dot_ms       = 16'd500;
		dash_ms      = 16'd1000;
		sgap_ms      = 16'd500;
		lgap_ms      = 16'd1000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_N; k++) begin
			send_char(dir_tab[k].code);
			if (dir_tab[k].typed) begin
				if (dir_tab[k].n_segs != 0) begin
					pending_segs.push_back(dir_tab[k].s0);
					pending_segs.push_back(dir_tab[k].s1);
				end
			end else begin
				queue_segments(dir_tab[k].code);
			end
		end
		s_tvalid <= 1'b0;
		wait_drained();

		for (ph = 0; ph < N_PHASES; ph++) begin
			case (ph)
				0: program_timing(16'd1, 16'd1, 16'd1, 16'd1, 8'd4);
				1: program_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
				// zero timings pass straight through
				2: program_timing(16'd0, ms_t'($urandom), 16'd0, ms_t'($urandom),
					cfg_idx_t'($urandom_range(4, 254)));
				3: program_timing(ms_t'($urandom_range(1, 65535)),
					ms_t'($urandom_range(1, 65535)), ms_t'($urandom_range(1, 65535)),
					ms_t'($urandom_range(1, 65535)), 8'h80);
				4: program_timing(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 8'h7F);
				default: program_timing(mlk_pkg::DOT_RESET, mlk_pkg::DASH_RESET,
					mlk_pkg::SYMBOL_GAP_RESET, mlk_pkg::LETTER_GAP_RESET, 8'h05);
			endcase
			no_idle  = (ph == 1);
			hold_req = (ph == 3);
			for (k = 0; k < RAND_PER_PHASE; k++) begin
				c = rand_char();
				send_char(c);
				queue_segments(c);
			end
			s_tvalid <= 1'b0;
			wait_drained();
		end

		if (err_cnt == 0)
			$display("[morse_letter_keyer_top] OK");
		else
			$display("[morse_letter_keyer_top] ERROR");
		$finish;
	end

endmodule
